[rtl/pvls_pkg.sv]
// ----------------------------------------------------------------------------
// pvls_pkg : shared types for the pump valve leak sequencer
// Flag layout, register indexes, configuration and result records.
// ----------------------------------------------------------------------------
package pvls_pkg;

   // register index codes of the configuration port
   localparam int CSR_INDEX_BITS = 2;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PUMP_LIMIT   = 2'd0,
      CSR_LEVEL_SETTLE = 2'd1,
      CSR_VALVE_LIMIT  = 2'd2,
      CSR_WATER_SETTLE = 2'd3
   } csr_index_type;

   localparam int CFG_BITS = 32;
   localparam int NOW_BITS = 32;

   // operation codes of a request beat
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_SET  = 1'b1
   } op_type;

   // flag index codes
   typedef enum logic [1:0] {
      FLAG_PUMP  = 2'd0,
      FLAG_VALVE = 2'd1,
      FLAG_FULL  = 2'd2,
      FLAG_LEAK  = 2'd3
   } flag_index_type;

   typedef struct packed {
      logic leak;
      logic full;
      logic valve;
      logic pump;
   } flags_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] pump_limit;
      logic [CFG_BITS-1:0] level_settle;
      logic [CFG_BITS-1:0] valve_limit;
      logic [CFG_BITS-1:0] water_settle;
   } cfg_type;

   typedef struct packed {
      op_type              operation;
      flag_index_type      flag_index;
      logic                flag_value;
      logic [NOW_BITS-1:0] now_ms;
      logic                level_high;
      logic                water_wet;
      logic                water_edge;
   } req_type;

   typedef struct packed {
      logic      changed;
      flags_type flags;
   } rsp_type;

endpackage

[rtl/pvls_req_if.sv]
// ----------------------------------------------------------------------------
// pvls_req_if : request channel
// Valid/ready channel carrying one command or tick beat.
// ----------------------------------------------------------------------------
interface pvls_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [1:0]  flag_index;
   logic        flag_value;
   logic [31:0] now_ms;
   logic        level_high;
   logic        water_wet;
   logic        water_edge;

   modport source (
      output valid, operation, flag_index, flag_value, now_ms,
             level_high, water_wet, water_edge,
      input  ready
   );
   modport sink (
      input  valid, operation, flag_index, flag_value, now_ms,
             level_high, water_wet, water_edge,
      output ready
   );
endinterface

[rtl/pvls_rsp_if.sv]
// ----------------------------------------------------------------------------
// pvls_rsp_if : response channel
// Valid/ready channel carrying the committed flags and the change bit.
// ----------------------------------------------------------------------------
interface pvls_rsp_if;
   logic valid;
   logic ready;
   logic changed;
   logic pump_on;
   logic valve_on;
   logic tank_full;
   logic leak_on;

   modport source (
      output valid, changed, pump_on, valve_on, tank_full, leak_on,
      input  ready
   );
   modport sink (
      input  valid, changed, pump_on, valve_on, tank_full, leak_on,
      output ready
   );
endinterface

[rtl/pvls_csr_if.sv]
// ----------------------------------------------------------------------------
// pvls_csr_if : configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pvls_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

[rtl/pvls_step.sv]
// ----------------------------------------------------------------------------
// pvls_step : sequencer state and per-beat evaluation
// Holds flags, timers and latches; one pass of logic per accepted beat.
// ----------------------------------------------------------------------------
module pvls_step
   import pvls_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type result
);

   // compare width covers both elapsed times and the 32-bit limits
   localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

   flags_type            cur_ff, cur_in;
   flags_type            pend_ff, pend_in;
   logic                 level_pend_ff, level_pend_in;
   logic [TIME_BITS-1:0] level_start_ff, level_start_in;
   logic [TIME_BITS-1:0] pump_start_ff, pump_start_in;
   logic [TIME_BITS-1:0] valve_start_ff, valve_start_in;
   logic                 water_pend_ff, water_pend_in;
   logic [TIME_BITS-1:0] water_start_ff, water_start_in;

   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] water_start_cur;
   logic                 water_pend_cur;
   logic [CMP_BITS-1:0]  pump_since, level_since, valve_since, water_since;
   logic                 expect_wet;
   flags_type            work;

   assign now = TIME_BITS'(req.now_ms);

   // edge latch applies before any stage, on any beat
   assign water_pend_cur  = req.water_edge ? 1'b1 : water_pend_ff;
   assign water_start_cur = req.water_edge ? now  : water_start_ff;

   // elapsed times wrap modulo the timer width
   assign pump_since  = CMP_BITS'(TIME_BITS'(now - pump_start_ff));
   assign level_since = CMP_BITS'(TIME_BITS'(now - level_start_ff));
   assign valve_since = CMP_BITS'(TIME_BITS'(now - valve_start_ff));
   assign water_since = CMP_BITS'(TIME_BITS'(now - water_start_cur));
   assign expect_wet  = ~cur_ff.leak;

   // next state of flags, timers and latches
   always_comb begin
      cur_in         = cur_ff;
      pend_in        = pend_ff;
      level_pend_in  = level_pend_ff;
      level_start_in = level_start_ff;
      pump_start_in  = pump_start_ff;
      valve_start_in = valve_start_ff;
      water_pend_in  = water_pend_cur;
      water_start_in = water_start_cur;
      work           = pend_ff;
      result.changed = 1'b0;

      unique case (req.operation)
         OP_SET: begin
            unique case (req.flag_index)
               FLAG_PUMP:  work.pump  = req.flag_value;
               FLAG_VALVE: work.valve = req.flag_value;
               FLAG_FULL:  work.full  = req.flag_value;
               FLAG_LEAK:  work.leak  = req.flag_value;
               default:    work.pump  = req.flag_value;
            endcase
            pend_in = work;
         end
         OP_TICK: begin
            // pump start, or refusal on a full tank
            if (!cur_ff.pump && pend_ff.pump) begin
               if (cur_ff.full) begin
                  work.pump = 1'b0;
               end else begin
                  pump_start_in = now;
               end
            end
            // running pump: timeout or settled level switch ends the fill
            if (cur_ff.pump && pend_ff.pump) begin
               if (pump_since < CMP_BITS'(cfg.pump_limit)) begin
                  if (!level_pend_ff) begin
                     if (req.level_high) begin
                        level_pend_in  = 1'b1;
                        level_start_in = now;
                     end
                  end else if (level_since >= CMP_BITS'(cfg.level_settle)
                               && req.level_high) begin
                     work.pump     = 1'b0;
                     work.full     = 1'b1;
                     level_pend_in = 1'b0;
                  end
               end else begin
                  work.pump = 1'b0;
                  work.full = 1'b1;
               end
            end
            // flush timer
            if (!cur_ff.valve && pend_ff.valve) begin
               valve_start_in = now;
            end
            if (cur_ff.valve && pend_ff.valve
                && valve_since >= CMP_BITS'(cfg.valve_limit)) begin
               work.valve = 1'b0;
               work.full  = 1'b0;
            end
            // leak edge confirmation after settle time
            if (water_pend_cur && water_since >= CMP_BITS'(cfg.water_settle)) begin
               if (req.water_wet == expect_wet) begin
                  work.leak = expect_wet;
               end
               water_pend_in = 1'b0;
            end
            // committed leak forces drives off
            if (cur_ff.leak) begin
               work.pump  = 1'b0;
               work.valve = 1'b0;
            end
            result.changed = (cur_ff != work);
            cur_in         = work;
            pend_in        = work;
         end
         default: begin
            pend_in = work;
         end
      endcase

      result.flags = cur_in;
   end

   // state registers, updated on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff         <= '0;
         pend_ff        <= '0;
         level_pend_ff  <= 1'b0;
         level_start_ff <= '0;
         pump_start_ff  <= '0;
         valve_start_ff <= '0;
         water_pend_ff  <= 1'b0;
         water_start_ff <= '0;
      end else if (accept) begin
         cur_ff         <= cur_in;
         pend_ff        <= pend_in;
         level_pend_ff  <= level_pend_in;
         level_start_ff <= level_start_in;
         pump_start_ff  <= pump_start_in;
         valve_start_ff <= valve_start_in;
         water_pend_ff  <= water_pend_in;
         water_start_ff <= water_start_in;
      end
   end

endmodule

[rtl/pvls_out_buf.sv]
// ----------------------------------------------------------------------------
// pvls_out_buf : two-entry response buffer
// Output register plus skid entry so the request side keeps flowing.
// ----------------------------------------------------------------------------
module pvls_out_buf
   import pvls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    can_push,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop       = out_valid_ff && out_ready;
   assign can_push  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // pop first, then place the new beat behind whatever remains
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   // control flags reset, payload does not
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

[rtl/pump_valve_leak_sequencer_top.sv]
// ----------------------------------------------------------------------------
// pump_valve_leak_sequencer_top : fill pump / flush valve / leak sequencer
// Pending and committed flags with pump, valve and leak timers.
// ----------------------------------------------------------------------------
//
//   channel  dir  beat contents
//   -------  ---  --------------------------------------------------------
//   req      in   operation, flag_index, flag_value, now_ms, sensor bits
//   rsp      out  changed, pump_on, valve_on, tank_full, leak_on
//   csr      in   index (register number), data (32-bit limit)
//
// One request beat is accepted per cycle while the skid entry is free; its
// response leaves from the output register. All evaluation is a single pass
// from the state registers, so the flag loop sets one beat per cycle.
// reset (synchronous) clears flags, timers, latches and the limits.
// A stalled rsp fills the skid entry; req_ready drops only when both
// response entries are occupied. csr writes are always taken.
//
module pump_valve_leak_sequencer_top
   import pvls_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   pvls_req_if.sink   req,
   pvls_rsp_if.source rsp,
   pvls_csr_if.sink   csr
);

   cfg_type cfg_ff, cfg_in;
   req_type req_beat;
   rsp_type step_rsp;
   rsp_type out_rsp;
   logic    accept;
   logic    can_push;

   // configuration registers
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_PUMP_LIMIT:   cfg_in.pump_limit   = csr.data;
            CSR_LEVEL_SETTLE: cfg_in.level_settle = csr.data;
            CSR_VALVE_LIMIT:  cfg_in.valve_limit  = csr.data;
            CSR_WATER_SETTLE: cfg_in.water_settle = csr.data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request beat
   assign req.ready = can_push;
   assign accept    = req.valid && can_push;

   assign req_beat.operation  = op_type'(req.operation);
   assign req_beat.flag_index = flag_index_type'(req.flag_index);
   assign req_beat.flag_value = req.flag_value;
   assign req_beat.now_ms     = req.now_ms;
   assign req_beat.level_high = req.level_high;
   assign req_beat.water_wet  = req.water_wet;
   assign req_beat.water_edge = req.water_edge;

   pvls_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_beat),
      .cfg    (cfg_ff),
      .result (step_rsp)
   );

   pvls_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_rsp),
      .can_push  (can_push),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (out_rsp)
   );

   // response beat
   assign rsp.changed   = out_rsp.changed;
   assign rsp.pump_on   = out_rsp.flags.pump;
   assign rsp.valve_on  = out_rsp.flags.valve;
   assign rsp.tank_full = out_rsp.flags.full;
   assign rsp.leak_on   = out_rsp.flags.leak;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the pump valve leak sequencer
// Drives command and tick beats with bursty traffic against a stalling
// response sink. Every accepted beat runs through a local flag predictor, and
// each response beat is compared against the oldest predicted status.
// ----------------------------------------------------------------------------
module tb_top;
   import pvls_pkg::*;

   localparam int WATCHDOG_CYCLES = 200000;

   logic clock;
   logic reset;

   pvls_req_if req ();
   pvls_rsp_if rsp ();
   pvls_csr_if csr ();

   pump_valve_leak_sequencer_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // predictor state: limits, flags, timers and latches
   cfg_type         limits;
   flags_type       cur_flags;
   flags_type       pend_flags;
   logic            level_wait;
   logic [31:0]     level_t0;
   logic [31:0]     pump_t0;
   logic [31:0]     valve_t0;
   logic            water_wait;
   logic [31:0]     water_t0;

   rsp_type         status_due[$];
   int unsigned     mismatch_count;
   int              burst_left;
   int unsigned     hold_left;
   logic [31:0]     wall_ms;
   logic            sensor_wet;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] elapsed_ms(input logic [31:0] now, input logic [31:0] start);
      return now - start;
   endfunction

   // flag sequencer prediction for one accepted beat
   function automatic rsp_type advance_sequencer(input req_type r);
      rsp_type res;
      logic    pump_cur;
      logic    pump_pend;
      logic    valve_cur;
      logic    valve_pend;
      logic    leak_cur;
      res.changed = 1'b0;
      if (r.water_edge) begin
         water_wait = 1'b1;
         water_t0   = r.now_ms;
      end
      if (r.operation == OP_SET) begin
         pend_flags[r.flag_index] = r.flag_value;
      end else begin
         // pump stage
         pump_cur  = cur_flags.pump;
         pump_pend = pend_flags.pump;
         if (!pump_cur && pump_pend) begin
            if (cur_flags.full) pend_flags.pump = 1'b0;
            else pump_t0 = r.now_ms;
         end
         if (pump_cur && pump_pend) begin
            if (elapsed_ms(r.now_ms, pump_t0) < limits.pump_limit) begin
               if (!level_wait) begin
                  if (r.level_high) begin
                     level_wait = 1'b1;
                     level_t0   = r.now_ms;
                  end
               end else if (elapsed_ms(r.now_ms, level_t0) >= limits.level_settle
                            && r.level_high) begin
                  pend_flags.pump = 1'b0;
                  pend_flags.full = 1'b1;
                  level_wait      = 1'b0;
               end
            end else begin
               pend_flags.pump = 1'b0;
               pend_flags.full = 1'b1;
            end
         end
         // valve stage
         valve_cur  = cur_flags.valve;
         valve_pend = pend_flags.valve;
         if (!valve_cur && valve_pend) valve_t0 = r.now_ms;
         if (valve_cur && valve_pend
             && elapsed_ms(r.now_ms, valve_t0) >= limits.valve_limit) begin
            pend_flags.valve = 1'b0;
            pend_flags.full  = 1'b0;
         end
         // leak stage: confirm a latched edge, then a committed leak kills drives
         leak_cur = cur_flags.leak;
         if (water_wait && elapsed_ms(r.now_ms, water_t0) >= limits.water_settle) begin
            if (r.water_wet == !leak_cur) pend_flags.leak = !leak_cur;
            water_wait = 1'b0;
         end
         if (leak_cur) begin
            pend_flags.pump  = 1'b0;
            pend_flags.valve = 1'b0;
         end
         // commit
         if (cur_flags != pend_flags) begin
            cur_flags   = pend_flags;
            res.changed = 1'b1;
         end
      end
      res.flags = cur_flags;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic check_bit(input string field, input logic got, input logic want);
      if (got !== want) report_mismatch($sformatf("%s got %b want %b", field, got, want));
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready) begin
         if (status_due.size() == 0) begin
            report_mismatch("response beat with nothing expected");
         end else begin
            want = status_due.pop_front();
            check_bit("changed", rsp.changed, want.changed);
            check_bit("pump_on", rsp.pump_on, want.flags.pump);
            check_bit("valve_on", rsp.valve_on, want.flags.valve);
            check_bit("tank_full", rsp.tank_full, want.flags.full);
            check_bit("leak_on", rsp.leak_on, want.flags.leak);
         end
      end
   end

   // response sink: stall pattern in random modes, plus long hold-offs on request
   initial begin
      int unsigned mode_left;
      int unsigned ready_pct;
      rsp.ready = 1'b0;
      mode_left = 0;
      ready_pct = 100;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode_left = $urandom_range(10, 80);
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 75;
               2: ready_pct = 50;
               default: ready_pct = 20;
            endcase
         end
         mode_left--;
         if (hold_left > 0) begin
            rsp.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp.ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   // watchdog
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < WATCHDOG_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL pump_valve_leak_sequencer_top");
      $finish;
   end

   // one request beat, sent in bursts with random gaps between them
   task automatic send_beat(input req_type r);
      if (burst_left <= 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req.valid      <= 1'b1;
      req.operation  <= r.operation;
      req.flag_index <= r.flag_index;
      req.flag_value <= r.flag_value;
      req.now_ms     <= r.now_ms;
      req.level_high <= r.level_high;
      req.water_wet  <= r.water_wet;
      req.water_edge <= r.water_edge;
      do @(posedge clock); while (!req.ready);
      status_due.push_back(advance_sequencer(r));
   endtask

   task automatic send_tick(input logic [31:0] now, input logic level, input logic wet,
                            input logic edge_seen);
      req_type r;
      r            = '0;
      r.operation  = OP_TICK;
      r.flag_index = flag_index_type'($urandom_range(0, 3));
      r.now_ms     = now;
      r.level_high = level;
      r.water_wet  = wet;
      r.water_edge = edge_seen;
      wall_ms      = now;
      send_beat(r);
   endtask

   task automatic send_command(input flag_index_type flag, input logic value,
                               input logic edge_seen);
      req_type r;
      r            = '0;
      r.operation  = OP_SET;
      r.flag_index = flag;
      r.flag_value = value;
      r.now_ms     = wall_ms;
      r.level_high = 1'($urandom);
      r.water_wet  = sensor_wet;
      r.water_edge = edge_seen;
      send_beat(r);
   endtask

   // drop valid and wait until every predicted status has been checked
   task automatic wait_idle();
      req.valid <= 1'b0;
      burst_left = 0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      case (idx)
         CSR_PUMP_LIMIT:   limits.pump_limit   = value;
         CSR_LEVEL_SETTLE: limits.level_settle = value;
         CSR_VALVE_LIMIT:  limits.valve_limit  = value;
         default:          limits.water_settle = value;
      endcase
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_limits(input logic [31:0] pump_lim, input logic [31:0] level_set,
                              input logic [31:0] valve_lim, input logic [31:0] water_set);
      wait_idle();
      write_reg(CSR_PUMP_LIMIT, pump_lim);
      write_reg(CSR_LEVEL_SETTLE, level_set);
      write_reg(CSR_VALVE_LIMIT, valve_lim);
      write_reg(CSR_WATER_SETTLE, water_set);
   endtask

   // mostly plausible plant traffic, some raw noise
   task automatic random_item(input int unsigned step_ms);
      req_type      r;
      logic [63:0]  noise;
      int unsigned  pick;
      int unsigned  sel;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         noise = {$urandom, $urandom};
         r     = req_type'(noise[$bits(req_type)-1:0]);
         send_beat(r);
      end else begin
         r = '0;
         if ($urandom_range(0, 19) == 0) begin
            sensor_wet   = ~sensor_wet;
            r.water_edge = 1'b1;
         end
         r.water_wet = sensor_wet;
         if (pick < 40) begin
            sel          = $urandom_range(0, 9);
            r.operation  = OP_SET;
            r.flag_index = (sel < 4) ? FLAG_PUMP : (sel < 7) ? FLAG_VALVE :
                           (sel < 9) ? FLAG_FULL : FLAG_LEAK;
            r.flag_value = ($urandom_range(0, 3) != 0);
            r.level_high = 1'($urandom);
         end else begin
            r.operation  = OP_TICK;
            r.flag_index = flag_index_type'($urandom_range(0, 3));
            r.flag_value = 1'($urandom);
            wall_ms      = wall_ms + (($urandom_range(0, 15) == 0) ? $urandom
                                                                   : $urandom_range(0, step_ms));
            r.level_high = ($urandom_range(0, 99) < (cur_flags.pump ? 60 : 15));
         end
         r.now_ms = wall_ms;
         send_beat(r);
      end
   endtask

   // commands on every flag under reset limits, water edge on a command beat
   task automatic test_flag_commands();
      send_command(FLAG_PUMP, 1'b1, 1'b0);
      send_command(FLAG_VALVE, 1'b1, 1'b1);
      send_command(FLAG_FULL, 1'b1, 1'b0);
      send_command(FLAG_LEAK, 1'b1, 1'b0);
      send_tick(32'd0, 1'b1, 1'b1, 1'b0);
      send_command(FLAG_LEAK, 1'b0, 1'b0);
      send_command(FLAG_FULL, 1'b0, 1'b0);
      send_tick(32'd1, 1'b0, 1'b0, 1'b0);
   endtask

   // level settle ends a fill, refused fill when full, flush end, pump timeout
   task automatic test_fill_and_flush();
      load_limits(32'd100, 32'd10, 32'd50, 32'd20);
      send_command(FLAG_PUMP, 1'b1, 1'b0);
      send_tick(32'd1000, 1'b0, 1'b0, 1'b0);
      send_tick(32'd1005, 1'b1, 1'b0, 1'b0);
      send_tick(32'd1012, 1'b0, 1'b0, 1'b0);
      send_tick(32'd1020, 1'b1, 1'b0, 1'b0);
      send_command(FLAG_PUMP, 1'b1, 1'b0);
      send_tick(32'd1030, 1'b0, 1'b0, 1'b0);
      send_command(FLAG_VALVE, 1'b1, 1'b0);
      send_tick(32'd1040, 1'b0, 1'b0, 1'b0);
      send_tick(32'd1100, 1'b0, 1'b0, 1'b0);
      send_command(FLAG_PUMP, 1'b1, 1'b0);
      send_tick(32'd1110, 1'b0, 1'b0, 1'b0);
      send_tick(32'd1210, 1'b0, 1'b0, 1'b0);
   endtask

   // wet edge confirmed, leak forces drives off, dry edge with wrong reading
   task automatic test_leak_confirm();
      sensor_wet = 1'b1;
      send_tick(32'd2000, 1'b0, 1'b1, 1'b1);
      send_command(FLAG_PUMP, 1'b1, 1'b1);
      send_tick(32'd2030, 1'b0, 1'b1, 1'b0);
      send_tick(32'd2031, 1'b0, 1'b1, 1'b0);
      sensor_wet = 1'b0;
      send_tick(32'd2040, 1'b0, 1'b0, 1'b1);
      send_tick(32'd2070, 1'b0, 1'b1, 1'b0);
      send_tick(32'd2080, 1'b0, 1'b0, 1'b1);
      send_tick(32'd2100, 1'b0, 1'b0, 1'b0);
   endtask

   // elapsed times across the 32-bit wrap, then all limits at their maximum
   task automatic test_time_wrap();
      send_command(FLAG_PUMP, 1'b1, 1'b0);
      send_tick(32'hFFFF_FFC0, 1'b0, 1'b0, 1'b0);
      send_tick(32'h0000_0030, 1'b0, 1'b0, 1'b0);
      load_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_command(FLAG_VALVE, 1'b1, 1'b0);
      send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
      send_tick(32'hFFFF_FFFE, 1'b1, 1'b1, 1'b0);
   endtask

   // sink holds off for a long stretch while beats keep coming
   task automatic test_backpressure();
      load_limits(32'd40, 32'd5, 32'd30, 32'd8);
      hold_left  = 200;
      burst_left = 1000;
      repeat (60) random_item(20);
   endtask

   task automatic test_random_phases();
      load_limits($urandom_range(0, 80), $urandom_range(0, 30),
                  $urandom_range(0, 80), $urandom_range(0, 30));
      repeat (400) random_item(20);
      load_limits(32'd0, 32'd0, 32'd0, 32'd0);
      repeat (200) random_item(5);
      load_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      repeat (200) random_item(50);
      load_limits($urandom_range(0, 60), $urandom_range(0, 20),
                  $urandom_range(0, 60), $urandom_range(0, 20));
      repeat (400) random_item(15);
      load_limits(32'hFFFF_FFFF, 32'd0, $urandom_range(0, 40), 32'hFFFF_FFFF);
      repeat (150) random_item(20);
      load_limits(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 40));
      repeat (150) random_item(20);
   endtask

   initial begin
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.operation  = OP_TICK;
      req.flag_index = FLAG_PUMP;
      req.flag_value = 1'b0;
      req.now_ms     = '0;
      req.level_high = 1'b0;
      req.water_wet  = 1'b0;
      req.water_edge = 1'b0;
      csr.valid      = 1'b0;
      csr.index      = CSR_PUMP_LIMIT;
      csr.data       = '0;
      limits         = '0;
      cur_flags      = '0;
      pend_flags     = '0;
      level_wait     = 1'b0;
      level_t0       = '0;
      pump_t0        = '0;
      valve_t0       = '0;
      water_wait     = 1'b0;
      water_t0       = '0;
      mismatch_count = 0;
      burst_left     = 0;
      hold_left      = 0;
      wall_ms        = '0;
      sensor_wet     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_flag_commands();
      test_fill_and_flush();
      test_leak_confirm();
      test_time_wrap();
      test_backpressure();
      test_random_phases();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS pump_valve_leak_sequencer_top");
      end else begin
         $display("FAIL pump_valve_leak_sequencer_top");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/pvls_pkg.sv
rtl/pvls_req_if.sv
rtl/pvls_rsp_if.sv
rtl/pvls_csr_if.sv
rtl/pvls_step.sv
rtl/pvls_out_buf.sv
rtl/pump_valve_leak_sequencer_top.sv
verif/tb_top.sv
